// File: hdl/ttep_pkg.sv
`timescale 1ns / 1ps

package ttep_pkg;

	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_DRAW   = 3'd1,
		OP_ERASE  = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_SCROLL = 3'd4
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] row_a;
		logic [7:0] col_a;
		logic [7:0] span_end;
		logic [7:0] glyph;
	} cmd_t;

	typedef struct packed {
		logic [1:0] attr;
		logic [7:0] cur_row;
		logic [7:0] cur_col;
		logic       cur_visible;
		logic       insert_mode;
	} status_t;

	// Everything one byte produces: one or two commands plus the cursor status.
	typedef struct packed {
		cmd_t    cmd0;
		cmd_t    cmd1;
		logic    two;
		status_t status;
	} result_t;

	localparam cmd_t CMD_NONE = '{op: OP_NONE, row_a: 8'd0, col_a: 8'd0,
		span_end: 8'd0, glyph: 8'd0};

	function automatic logic is_hideable(input op_t op);
		return (op == OP_DRAW) || (op == OP_ERASE) || (op == OP_SCROLL);
	endfunction

endpackage

// File: hdl/text_terminal_escape_parser.sv
`timescale 1ns / 1ps
// Channel | Handshake              | Payload
// in      | in_valid / in_ready    | byte_in
// out     | out_valid / out_ready  | op, row_a, col_a, span_end, glyph, attr, cur_row,
//         |                        | cur_col, cur_visible, insert_mode, last
// cfg     | cfg_valid / cfg_ready  | hide_output
//
// A byte is registered on acceptance and, once the output register is free, is
// decoded straight into it. Bytes that give one command flow at one per cycle while
// out_ready stays high; a two-command byte holds the output register until both
// are taken. A byte's first command passes through byte_s1 and res_q to the port.
// Reset puts the cursor at the top left with the full screen as scroll region.
// A stall on the output backs up into the input register and then in_ready.

module text_terminal_escape_parser #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 30
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] op,
	output logic [7:0] row_a,
	output logic [7:0] col_a,
	output logic [7:0] span_end,
	output logic [7:0] glyph,
	output logic [1:0] attr,
	output logic [7:0] cur_row,
	output logic [7:0] cur_col,
	output logic       cur_visible,
	output logic       insert_mode,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       hide_output
);
	import ttep_pkg::*;

	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       hide_q;
	result_t    step_res;
	result_t    res_q;
	logic       out_valid_q;
	logic       second_q;
	logic       out_done;
	logic       out_free;
	logic       advance;
	cmd_t       cur_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hide_q <= 1'b0;
		end else if (cfg_valid) begin
			hide_q <= hide_output;
		end
	end

	ttep_parser #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_in (byte_s1),
		.hide    (hide_q),
		.result  (step_res)
	);

	assign last     = res_q.two ? second_q : 1'b1;
	assign out_done = out_valid_q && out_ready && last;
	assign out_free = !out_valid_q || out_done;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= byte_in;
		if (advance) res_q <= step_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			second_q    <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			if (last) out_valid_q <= 1'b0;
			else second_q <= 1'b1;
		end
	end

	assign cur_cmd     = second_q ? res_q.cmd1 : res_q.cmd0;
	assign out_valid   = out_valid_q;
	assign op          = cur_cmd.op;
	assign row_a       = cur_cmd.row_a;
	assign col_a       = cur_cmd.col_a;
	assign span_end    = cur_cmd.span_end;
	assign glyph       = cur_cmd.glyph;
	assign attr        = res_q.status.attr;
	assign cur_row     = res_q.status.cur_row;
	assign cur_col     = res_q.status.cur_col;
	assign cur_visible = res_q.status.cur_visible;
	assign insert_mode = res_q.status.insert_mode;

endmodule

// File: hdl/ttep_parser.sv
`timescale 1ns / 1ps

module ttep_parser #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic [7:0]          byte_in,
	input  logic                hide,
	output ttep_pkg::result_t   result
);
	import ttep_pkg::*;

	typedef enum logic [2:0] {
		PS_IDLE = 3'd0,
		PS_ESC  = 3'd1,
		PS_CSI  = 3'd2,
		PS_NUM1 = 3'd3,
		PS_PRIV = 3'd4,
		PS_SEMI = 3'd5,
		PS_NUM2 = 3'd6,
		PS_PNUM = 3'd7
	} pstate_t;

	localparam logic [7:0]  CH_BS   = 8'h08;
	localparam logic [7:0]  CH_TAB  = 8'h09;
	localparam logic [7:0]  CH_LF   = 8'h0A;
	localparam logic [7:0]  CH_CR   = 8'h0D;
	localparam logic [7:0]  CH_ESC  = 8'h1B;
	localparam logic [7:0]  CH_SP   = 8'h20;
	localparam logic [7:0]  CH_ZERO = 8'h30;
	localparam logic [7:0]  CH_NINE = 8'h39;

	localparam logic [7:0]  COLS8    = 8'(COLUMNS);
	localparam logic [8:0]  COLS9    = 9'(COLUMNS);
	localparam logic [11:0] COLS12   = 12'(COLUMNS);
	localparam logic [7:0]  COL_LAST = 8'(COLUMNS - 1);
	localparam logic [8:0]  ROWS9    = 9'(ROWS);
	localparam logic [10:0] ROWS11   = 11'(ROWS);
	localparam logic [9:0]  NUM1_MAX = 10'd99;
	localparam logic [10:0] NUM2_MAX = 11'd199;
	localparam logic [9:0]  MODE_INSERT = 10'd4;
	localparam logic [9:0]  MODE_CURSOR = 10'd25;
	localparam logic [9:0]  SGR_NORMAL  = 10'd0;
	localparam logic [9:0]  SGR_BOLD    = 10'd1;
	localparam logic [9:0]  SGR_FAINT   = 10'd2;
	localparam logic [9:0]  SGR_RESET   = 10'd27;
	localparam logic [1:0]  ATTR_NORMAL = 2'd0;
	localparam logic [1:0]  ATTR_HIGH   = 2'd1;
	localparam logic [1:0]  ATTR_HALF   = 2'd2;

	pstate_t     pstate_q, pstate_d;
	logic [9:0]  num1_q, num1_d;
	logic [10:0] num2_q, num2_d;
	logic [7:0]  row_q, row_d;
	logic [7:0]  col_q, col_d;
	logic [7:0]  top_q, top_d;
	logic [8:0]  bottom_q, bottom_d;
	logic [1:0]  attr_q, attr_d;
	logic        show_q, show_d;
	logic        ins_q, ins_d;

	cmd_t        raw_a, raw_b;
	logic        raw_a_vld, raw_b_vld;
	logic        keep_a, keep_b;

	logic        is_digit;
	logic [3:0]  digit;
	logic        at_bottom;
	logic [8:0]  col_inc;
	logic [8:0]  tab_col;
	logic [9:0]  num1_acc;
	logic [10:0] num2_acc;
	logic [11:0] erase_end;
	logic [10:0] r_m1, c_m1, t_m1;
	cmd_t        scroll_cmd;

	assign is_digit  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
	assign digit     = byte_in[3:0];
	// Moving down from the last region row scrolls instead of moving.
	assign at_bottom = ({1'b0, row_q} + 9'd1) >= bottom_q;
	assign col_inc   = {1'b0, col_q} + 9'd1;
	assign tab_col   = {({1'b0, col_q[7:3]} + 6'd1), 3'b000};
	assign num1_acc  = (num1_q << 3) + (num1_q << 1) + 10'(digit);
	assign num2_acc  = (num2_q << 3) + (num2_q << 1) + 11'(digit);
	assign erase_end = 12'(col_q) + 12'(num1_q);
	assign r_m1      = 11'(num1_q) - 11'd1;
	assign c_m1      = num2_q - 11'd1;
	assign t_m1      = r_m1;
	assign scroll_cmd = '{op: OP_SCROLL, row_a: top_q, col_a: 8'd0,
		span_end: bottom_q[7:0], glyph: 8'd0};

	always_comb begin
		pstate_d  = PS_IDLE;
		num1_d    = num1_q;
		num2_d    = num2_q;
		row_d     = row_q;
		col_d     = col_q;
		top_d     = top_q;
		bottom_d  = bottom_q;
		attr_d    = attr_q;
		show_d    = show_q;
		ins_d     = ins_q;
		raw_a     = CMD_NONE;
		raw_b     = CMD_NONE;
		raw_a_vld = 1'b0;
		raw_b_vld = 1'b0;

		unique case (pstate_q)
			PS_IDLE: begin
				if (byte_in == CH_BS) begin
					if (col_q != 8'd0) begin
						col_d = col_q - 8'd1;
					end else if (row_q > top_q) begin
						col_d = COL_LAST;
						row_d = row_q - 8'd1;
					end
				end else if (byte_in == CH_TAB) begin
					if (tab_col >= COLS9) begin
						col_d = 8'd0;
						if (at_bottom) begin
							raw_a     = scroll_cmd;
							raw_a_vld = 1'b1;
						end else begin
							row_d = row_q + 8'd1;
						end
					end else begin
						col_d = tab_col[7:0];
					end
				end else if (byte_in == CH_LF) begin
					col_d = 8'd0;
					if (at_bottom) begin
						raw_a     = scroll_cmd;
						raw_a_vld = 1'b1;
					end else begin
						row_d = row_q + 8'd1;
					end
				end else if (byte_in == CH_CR) begin
					col_d = 8'd0;
				end else if (byte_in == CH_ESC) begin
					pstate_d = PS_ESC;
				end else if (byte_in >= CH_SP) begin
					raw_a     = '{op: OP_DRAW, row_a: row_q, col_a: col_q,
						span_end: 8'd0, glyph: byte_in};
					raw_a_vld = 1'b1;
					if (col_inc >= COLS9) begin
						col_d = 8'd0;
						if (at_bottom) begin
							raw_b     = scroll_cmd;
							raw_b_vld = 1'b1;
						end else begin
							row_d = row_q + 8'd1;
						end
					end else begin
						col_d = col_inc[7:0];
					end
				end
			end
			PS_ESC: begin
				if (byte_in == "[") pstate_d = PS_CSI;
			end
			PS_CSI: begin
				if (byte_in == "?") begin
					pstate_d = PS_PRIV;
				end else if (byte_in == "A") begin
					if (row_q > top_q) row_d = row_q - 8'd1;
				end else if (byte_in == "B") begin
					if (at_bottom) begin
						raw_a     = scroll_cmd;
						raw_a_vld = 1'b1;
					end else begin
						row_d = row_q + 8'd1;
					end
				end else if (byte_in == "C") begin
					if (col_inc >= COLS9) begin
						col_d = 8'd0;
						if (at_bottom) begin
							raw_a     = scroll_cmd;
							raw_a_vld = 1'b1;
						end else begin
							row_d = row_q + 8'd1;
						end
					end else begin
						col_d = col_inc[7:0];
					end
				end else if (byte_in == "D") begin
					if (col_q != 8'd0) begin
						col_d = col_q - 8'd1;
					end else if (row_q > top_q) begin
						col_d = COL_LAST;
						row_d = row_q - 8'd1;
					end
				end else if (byte_in == "H") begin
					col_d = 8'd0;
					row_d = top_q;
				end else if (byte_in == "J" || byte_in == "K") begin
					raw_a     = '{op: OP_ERASE, row_a: row_q, col_a: col_q,
						span_end: COLS8, glyph: 8'd0};
					raw_a_vld = 1'b1;
					if (byte_in == "J") begin
						raw_b     = '{op: OP_CLEAR, row_a: row_q + 8'd1, col_a: 8'd0,
							span_end: 8'd0, glyph: 8'd0};
						raw_b_vld = 1'b1;
					end
				end else if (is_digit) begin
					num1_d   = 10'(digit);
					pstate_d = PS_NUM1;
				end
			end
			PS_NUM1: begin
				if (byte_in == ";") begin
					pstate_d = PS_SEMI;
				end else if (byte_in == "X") begin
					if (num1_q != 10'd0) begin
						raw_a     = '{op: OP_ERASE, row_a: row_q, col_a: col_q,
							span_end: (erase_end > COLS12) ? COLS8 : erase_end[7:0],
							glyph: 8'd0};
						raw_a_vld = 1'b1;
					end
				end else if (byte_in == "h" || byte_in == "l") begin
					if (num1_q == MODE_INSERT) ins_d = (byte_in == "h");
				end else if (byte_in == "m") begin
					if (num1_q == SGR_NORMAL || num1_q == SGR_RESET) attr_d = ATTR_NORMAL;
					else if (num1_q == SGR_BOLD) attr_d = ATTR_HIGH;
					else if (num1_q == SGR_FAINT) attr_d = ATTR_HALF;
				end else if (is_digit) begin
					num1_d   = num1_acc;
					pstate_d = (num1_acc > NUM1_MAX) ? PS_IDLE : PS_NUM1;
				end
			end
			PS_PRIV: begin
				if (is_digit) begin
					num1_d   = 10'(digit);
					pstate_d = PS_PNUM;
				end
			end
			PS_SEMI: begin
				if (is_digit) begin
					num2_d   = 11'(digit);
					pstate_d = PS_NUM2;
				end
			end
			PS_NUM2: begin
				if (byte_in == "H") begin
					if (num1_q != 10'd0 && num2_q != 11'd0 && c_m1 < 11'(COLUMNS)
						&& r_m1 >= 11'(top_q) && r_m1 < 11'(bottom_q)) begin
						col_d = c_m1[7:0];
						row_d = r_m1[7:0];
					end
				end else if (byte_in == "r") begin
					// An invalid region is ignored, but the cursor is homed anyway.
					col_d = 8'd0;
					row_d = top_q;
					if (num1_q != 10'd0 && t_m1 < ROWS11 && num2_q != 11'd0
						&& num2_q <= ROWS11 && t_m1 < num2_q) begin
						top_d    = t_m1[7:0];
						bottom_d = num2_q[8:0];
						row_d    = t_m1[7:0];
					end
				end else if (is_digit) begin
					num2_d   = num2_acc;
					pstate_d = (num2_acc > NUM2_MAX) ? PS_IDLE : PS_NUM2;
				end
			end
			PS_PNUM: begin
				if (byte_in == "h" || byte_in == "l") begin
					if (num1_q == MODE_CURSOR) show_d = (byte_in == "h");
				end else if (is_digit) begin
					num1_d   = num1_acc;
					pstate_d = (num1_acc > NUM1_MAX) ? PS_IDLE : PS_PNUM;
				end
			end
		endcase
	end

	assign keep_a = raw_a_vld && !(hide && is_hideable(raw_a.op));
	assign keep_b = raw_b_vld && !(hide && is_hideable(raw_b.op));

	always_comb begin
		result.two  = keep_a && keep_b;
		result.cmd1 = raw_b;
		if (keep_a) result.cmd0 = raw_a;
		else if (keep_b) result.cmd0 = raw_b;
		else result.cmd0 = CMD_NONE;
		result.status.attr        = attr_d;
		result.status.cur_row     = row_d;
		result.status.cur_col     = col_d;
		result.status.cur_visible = show_d;
		result.status.insert_mode = ins_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstate_q <= PS_IDLE;
			num1_q   <= '0;
			num2_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
			top_q    <= '0;
			bottom_q <= ROWS9;
			attr_q   <= ATTR_NORMAL;
			show_q   <= 1'b1;
			ins_q    <= 1'b0;
		end else if (advance) begin
			pstate_q <= pstate_d;
			num1_q   <= num1_d;
			num2_q   <= num2_d;
			row_q    <= row_d;
			col_q    <= col_d;
			top_q    <= top_d;
			bottom_q <= bottom_d;
			attr_q   <= attr_d;
			show_q   <= show_d;
			ins_q    <= ins_d;
		end
	end

endmodule

// File: hdl/ttep_checker.sv
`timescale 1ns / 1ps

module ttep_checker #(
	parameter int COLUMNS = 80
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] op,
	input logic [1:0] attr,
	input logic [7:0] cur_col,
	input logic       last
);
	import ttep_pkg::*;

	// A stalled command holds its code and its position in the byte's group.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(op) && $stable(last))
		else $error("output command changed while stalled");

	// The second command of a byte is already buffered and follows at once.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("second command of a byte did not follow");

	a_op_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (op == OP_NONE || op == OP_DRAW || op == OP_ERASE
			|| op == OP_CLEAR || op == OP_SCROLL))
		else $error("unknown command code");

	a_cursor_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(cur_col) < COLUMNS) && (attr != 2'd3))
		else $error("cursor column or attribute out of range");

endmodule

bind text_terminal_escape_parser ttep_checker #(.COLUMNS(COLUMNS)) u_ttep_checker (.*);
